// ===== rtl/core/wncc_pkg.sv =====
// Shared constants and types of the weighted normalized cross-correlation unit.
package wncc_pkg;

   localparam int MAG_BITS         = 20;
   localparam int WEIGHT_BITS      = 9;
   localparam int WEIGHT_FRAC_BITS = 8;
   localparam int MAX_ELEMENTS     = 1048576;
   localparam int CNT_BITS         = 21;
   localparam int SUM_BITS         = 40;
   localparam int SQ_BITS          = 60;
   localparam int PROD_BITS        = 2 * MAG_BITS;
   localparam int REQ_DATA_BITS    = 56;
   localparam int SCORE_BITS       = 16;

   localparam int LIMB_BITS      = 32;
   localparam int MUL_LIMBS      = 6;
   localparam int OPND_BITS      = MUL_LIMBS * LIMB_BITS;
   localparam int ACC_BITS       = 224;
   localparam int WIDE_BITS      = 96;
   localparam int LIMB_IDX_BITS  = 3;
   localparam int SHIFT_IDX_BITS = 4;

   typedef struct packed {
      logic [CNT_BITS-1:0] cnt;
      logic [SUM_BITS-1:0] sum_img;
      logic [SUM_BITS-1:0] sum_ref;
      logic [SQ_BITS-1:0]  sum_img_sq;
      logic [SQ_BITS-1:0]  sum_ref_sq;
      logic [SQ_BITS-1:0]  sum_cross;
   } sums_type;

   typedef struct packed {
      logic                     start;
      logic [LIMB_IDX_BITS-1:0] na;
      logic [LIMB_IDX_BITS-1:0] nb;
   } mul_cmd_type;

endpackage

// ===== rtl/core/wncc_front.sv =====
// Front end: weighting, products and running sums; pushes a snapshot per data set.
module wncc_front import wncc_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [REQ_DATA_BITS-1:0] req_tdata,
   input  logic                     req_tlast,
   output logic                     q_push,
   output sums_type                 q_data,
   input  logic                     q_full
);

   localparam logic [WEIGHT_BITS-1:0] WEIGHT_ONE = WEIGHT_BITS'(1 << WEIGHT_FRAC_BITS);
   localparam int WPROD_BITS = MAG_BITS + WEIGHT_BITS;

   logic                   adv;
   logic [MAG_BITS-1:0]    img, refm;
   logic [WEIGHT_BITS-1:0] wraw, wc;
   logic [WPROD_BITS-1:0]  img_w, ref_w;

   logic                s1_valid_ff, s1_last_ff;
   logic [MAG_BITS-1:0] s1_wa_ff, s1_wb_ff;
   logic                s2_valid_ff, s2_last_ff;
   logic [MAG_BITS-1:0] s2_wa_ff, s2_wb_ff;
   logic [PROD_BITS-1:0] s2_aa_ff, s2_bb_ff, s2_ab_ff;

   sums_type acc_ff, acc_in;
   logic     go, en;

   assign adv        = !(s2_valid_ff && s2_last_ff && q_full);
   assign req_tready = adv;

   assign img  = req_tdata[MAG_BITS-1:0];
   assign refm = req_tdata[2*MAG_BITS-1:MAG_BITS];
   assign wraw = req_tdata[2*MAG_BITS +: WEIGHT_BITS];
   assign wc   = (wraw > WEIGHT_ONE) ? WEIGHT_ONE : wraw;

   assign img_w = WPROD_BITS'(img) * WPROD_BITS'(wc);
   assign ref_w = WPROD_BITS'(refm) * WPROD_BITS'(wc);

   assign go = adv && s2_valid_ff;
   assign en = acc_ff.cnt < CNT_BITS'(MAX_ELEMENTS);

   always_comb begin
      acc_in = acc_ff;
      if (en) begin
         acc_in.cnt        = acc_ff.cnt + 1'b1;
         acc_in.sum_img    = acc_ff.sum_img + SUM_BITS'(s2_wa_ff);
         acc_in.sum_ref    = acc_ff.sum_ref + SUM_BITS'(s2_wb_ff);
         acc_in.sum_img_sq = acc_ff.sum_img_sq + SQ_BITS'(s2_aa_ff);
         acc_in.sum_ref_sq = acc_ff.sum_ref_sq + SQ_BITS'(s2_bb_ff);
         acc_in.sum_cross  = acc_ff.sum_cross + SQ_BITS'(s2_ab_ff);
      end
   end

   assign q_push = go && s2_last_ff;
   assign q_data = acc_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         acc_ff      <= '0;
      end else if (adv) begin
         s1_valid_ff <= req_tvalid;
         s2_valid_ff <= s1_valid_ff;
         if (s2_valid_ff) begin
            acc_ff <= s2_last_ff ? '0 : acc_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_last_ff <= req_tlast;
         s1_wa_ff   <= img_w[WEIGHT_FRAC_BITS +: MAG_BITS];
         s1_wb_ff   <= ref_w[WEIGHT_FRAC_BITS +: MAG_BITS];
         s2_last_ff <= s1_last_ff;
         s2_wa_ff   <= s1_wa_ff;
         s2_wb_ff   <= s1_wb_ff;
         s2_aa_ff   <= PROD_BITS'(s1_wa_ff) * PROD_BITS'(s1_wa_ff);
         s2_bb_ff   <= PROD_BITS'(s1_wb_ff) * PROD_BITS'(s1_wb_ff);
         s2_ab_ff   <= PROD_BITS'(s1_wa_ff) * PROD_BITS'(s1_wb_ff);
      end
   end

endmodule

// ===== rtl/core/wncc_queue.sv =====
// Two-entry queue of per-set sum snapshots between front and back end.
module wncc_queue import wncc_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     wr_en,
   input  sums_type wr_data,
   output logic     full,
   input  logic     rd_en,
   output sums_type rd_data,
   output logic     empty
);

   sums_type   mem_ff [2];
   logic       wp_ff, rp_ff;
   logic [1:0] cnt_ff;

   assign full    = cnt_ff == 2'd2;
   assign empty   = cnt_ff == 2'd0;
   assign rd_data = mem_ff[rp_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         if (wr_en) begin
            wp_ff <= ~wp_ff;
         end
         if (rd_en) begin
            rp_ff <= ~rp_ff;
         end
         if (wr_en && !rd_en) begin
            cnt_ff <= cnt_ff + 2'd1;
         end else if (rd_en && !wr_en) begin
            cnt_ff <= cnt_ff - 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wp_ff] <= wr_data;
      end
   end

endmodule

// ===== rtl/core/wncc_mul.sv =====
// Multi-cycle wide multiplier: one 32x32 limb product per cycle, accumulated.
module wncc_mul import wncc_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  mul_cmd_type         cmd,
   input  logic [OPND_BITS-1:0] opnd_a,
   input  logic [OPND_BITS-1:0] opnd_b,
   output logic                done,
   output logic [ACC_BITS-1:0] prod
);

   logic [MUL_LIMBS-1:0][LIMB_BITS-1:0] a_ff, b_ff;
   logic [LIMB_IDX_BITS-1:0]  na_ff, nb_ff, i_ff, j_ff;
   logic                      run_ff, pp_valid_ff, pp_last_ff, done_ff;
   logic [2*LIMB_BITS-1:0]    pp_ff;
   logic [SHIFT_IDX_BITS-1:0] k_ff;
   logic [ACC_BITS-1:0]       acc_ff, pp_shifted;
   logic                      i_end, j_end;

   assign i_end = i_ff == na_ff - 1'b1;
   assign j_end = j_ff == nb_ff - 1'b1;
   assign pp_shifted = ACC_BITS'(pp_ff) << {k_ff, 5'b0};
   assign done = done_ff;
   assign prod = acc_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff      <= 1'b0;
         pp_valid_ff <= 1'b0;
         pp_last_ff  <= 1'b0;
         done_ff     <= 1'b0;
      end else begin
         done_ff     <= pp_valid_ff && pp_last_ff;
         pp_valid_ff <= run_ff;
         pp_last_ff  <= run_ff && i_end && j_end;
         if (cmd.start) begin
            run_ff <= 1'b1;
         end else if (run_ff && i_end && j_end) begin
            run_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      pp_ff <= (2*LIMB_BITS)'(a_ff[i_ff]) * (2*LIMB_BITS)'(b_ff[j_ff]);
      k_ff  <= SHIFT_IDX_BITS'(i_ff) + SHIFT_IDX_BITS'(j_ff);
      if (cmd.start) begin
         a_ff   <= opnd_a;
         b_ff   <= opnd_b;
         na_ff  <= cmd.na;
         nb_ff  <= cmd.nb;
         i_ff   <= '0;
         j_ff   <= '0;
         acc_ff <= '0;
      end else begin
         if (run_ff) begin
            if (j_end) begin
               j_ff <= '0;
               i_ff <= i_ff + 1'b1;
            end else begin
               j_ff <= j_ff + 1'b1;
            end
         end
         if (pp_valid_ff) begin
            acc_ff <= acc_ff + pp_shifted;
         end
      end
   end

endmodule

// ===== rtl/core/wncc_back.sv =====
// Back end: variance, covariance and bitwise score search per snapshot.
module wncc_back import wncc_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  q_empty,
   output logic                  q_pop,
   input  sums_type              q_data,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [SCORE_BITS-1:0] rsp_tdata,
   output logic                  rsp_tuser
);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_LAUNCH = 3'd1;
   localparam logic [2:0] ST_WAIT   = 3'd2;
   localparam logic [2:0] ST_BIT    = 3'd3;
   localparam logic [2:0] ST_DONE   = 3'd4;

   localparam logic [3:0] OP_NAA = 4'd0;
   localparam logic [3:0] OP_AA  = 4'd1;
   localparam logic [3:0] OP_NBB = 4'd2;
   localparam logic [3:0] OP_BB  = 4'd3;
   localparam logic [3:0] OP_NAB = 4'd4;
   localparam logic [3:0] OP_AB  = 4'd5;
   localparam logic [3:0] OP_P   = 4'd6;
   localparam logic [3:0] OP_C2  = 4'd7;
   localparam logic [3:0] OP_L   = 4'd8;

   localparam int R_SHIFT = 30;
   localparam logic [SCORE_BITS:0] MID_SCORE = (SCORE_BITS+1)'(1 << (SCORE_BITS - 1));

   logic [2:0]  st_ff;
   logic [3:0]  op_ff;
   sums_type    sums_ff;
   logic [WIDE_BITS-1:0] t1_ff, va_ff, vb_ff, cov_ff;
   logic                 neg_ff, flat_ff;
   logic [2*WIDE_BITS-1:0] p_ff;
   logic [ACC_BITS-1:0]    r_ff;
   logic [SCORE_BITS-1:0]  s_ff;
   logic [3:0]             bit_ff;

   logic rsp_valid_ff, rsp_flat_ff;
   logic [SCORE_BITS-1:0] rsp_score_ff;

   mul_cmd_type          cmd;
   logic [OPND_BITS-1:0] opnd_a, opnd_b;
   logic                 mul_done;
   logic [ACC_BITS-1:0]  prod;

   logic [WIDE_BITS-1:0] t2, diff_ba;
   logic [WIDE_BITS:0]   diff_ab;
   logic                 borrow, nonpos;
   logic [SCORE_BITS-1:0] cand;
   logic [SCORE_BITS:0]   tval, tneg;
   logic [SCORE_BITS-2:0] tmag;
   logic [2*(SCORE_BITS-1)-1:0] tt;
   logic                  t_pos, t_le0, l_ok, out_free;

   assign t2      = prod[WIDE_BITS-1:0];
   assign diff_ab = {1'b0, t1_ff} - {1'b0, t2};
   assign diff_ba = t2 - t1_ff;
   assign borrow  = diff_ab[WIDE_BITS];
   assign nonpos  = borrow || (diff_ab[WIDE_BITS-1:0] == '0);

   assign cand  = s_ff | (SCORE_BITS'(1) << bit_ff);
   assign tval  = {1'b0, cand} - MID_SCORE;
   assign tneg  = '0 - tval;
   assign tmag  = tval[SCORE_BITS] ? tneg[SCORE_BITS-2:0] : tval[SCORE_BITS-2:0];
   assign tt    = (2*(SCORE_BITS-1))'(tmag) * (2*(SCORE_BITS-1))'(tmag);
   assign t_pos = !tval[SCORE_BITS] && (tval != '0);
   assign t_le0 = !t_pos;
   assign l_ok  = t_pos ? (prod <= r_ff) : (prod >= r_ff);

   assign out_free = !rsp_valid_ff || rsp_tready;
   assign q_pop    = (st_ff == ST_IDLE) && !q_empty;

   always_comb begin
      cmd.start = st_ff == ST_LAUNCH;
      cmd.na    = 3'd2;
      cmd.nb    = 3'd2;
      opnd_a    = '0;
      opnd_b    = '0;
      case (op_ff)
         OP_NAA: begin
            opnd_a = OPND_BITS'(sums_ff.cnt);
            opnd_b = OPND_BITS'(sums_ff.sum_img_sq);
            cmd.na = 3'd1;
         end
         OP_AA: begin
            opnd_a = OPND_BITS'(sums_ff.sum_img);
            opnd_b = OPND_BITS'(sums_ff.sum_img);
         end
         OP_NBB: begin
            opnd_a = OPND_BITS'(sums_ff.cnt);
            opnd_b = OPND_BITS'(sums_ff.sum_ref_sq);
            cmd.na = 3'd1;
         end
         OP_BB: begin
            opnd_a = OPND_BITS'(sums_ff.sum_ref);
            opnd_b = OPND_BITS'(sums_ff.sum_ref);
         end
         OP_NAB: begin
            opnd_a = OPND_BITS'(sums_ff.cnt);
            opnd_b = OPND_BITS'(sums_ff.sum_cross);
            cmd.na = 3'd1;
         end
         OP_AB: begin
            opnd_a = OPND_BITS'(sums_ff.sum_img);
            opnd_b = OPND_BITS'(sums_ff.sum_ref);
         end
         OP_P: begin
            opnd_a = OPND_BITS'(va_ff);
            opnd_b = OPND_BITS'(vb_ff);
            cmd.na = 3'd3;
            cmd.nb = 3'd3;
         end
         OP_C2: begin
            opnd_a = OPND_BITS'(cov_ff);
            opnd_b = OPND_BITS'(cov_ff);
            cmd.na = 3'd3;
            cmd.nb = 3'd3;
         end
         OP_L: begin
            opnd_a = OPND_BITS'(tt);
            opnd_b = OPND_BITS'(p_ff);
            cmd.na = 3'd1;
            cmd.nb = 3'd6;
         end
         default: begin
            opnd_a = '0;
         end
      endcase
   end

   wncc_mul u_mul (
      .clock  (clock),
      .reset  (reset),
      .cmd    (cmd),
      .opnd_a (opnd_a),
      .opnd_b (opnd_b),
      .done   (mul_done),
      .prod   (prod)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff        <= ST_IDLE;
         op_ff        <= OP_NAA;
         rsp_valid_ff <= 1'b0;
      end else begin
         if ((st_ff == ST_DONE) && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (st_ff)
            ST_IDLE: begin
               if (!q_empty) begin
                  op_ff <= OP_NAA;
                  st_ff <= ST_LAUNCH;
               end
            end
            ST_LAUNCH: begin
               st_ff <= ST_WAIT;
            end
            ST_WAIT: begin
               if (mul_done) begin
                  case (op_ff)
                     OP_AA, OP_BB: begin
                        if (nonpos) begin
                           st_ff <= ST_DONE;
                        end else begin
                           op_ff <= op_ff + 4'd1;
                           st_ff <= ST_LAUNCH;
                        end
                     end
                     OP_C2: begin
                        st_ff <= ST_BIT;
                     end
                     OP_L: begin
                        st_ff <= (bit_ff == 4'd0) ? ST_DONE : ST_BIT;
                     end
                     default: begin
                        op_ff <= op_ff + 4'd1;
                        st_ff <= ST_LAUNCH;
                     end
                  endcase
               end
            end
            ST_BIT: begin
               if ((t_le0 && !neg_ff) || (t_pos && neg_ff)) begin
                  st_ff <= (bit_ff == 4'd0) ? ST_DONE : ST_BIT;
               end else begin
                  op_ff <= OP_L;
                  st_ff <= ST_LAUNCH;
               end
            end
            ST_DONE: begin
               if (out_free) begin
                  st_ff <= ST_IDLE;
               end
            end
            default: begin
               st_ff <= ST_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      case (st_ff)
         ST_IDLE: begin
            sums_ff <= q_data;
            flat_ff <= 1'b0;
            s_ff    <= '0;
            bit_ff  <= 4'd15;
         end
         ST_WAIT: begin
            if (mul_done) begin
               case (op_ff)
                  OP_NAA, OP_NBB, OP_NAB: begin
                     t1_ff <= t2;
                  end
                  OP_AA: begin
                     va_ff   <= diff_ab[WIDE_BITS-1:0];
                     flat_ff <= nonpos;
                  end
                  OP_BB: begin
                     vb_ff   <= diff_ab[WIDE_BITS-1:0];
                     flat_ff <= nonpos;
                  end
                  OP_AB: begin
                     neg_ff <= borrow;
                     cov_ff <= borrow ? diff_ba : diff_ab[WIDE_BITS-1:0];
                  end
                  OP_P: begin
                     p_ff <= prod[2*WIDE_BITS-1:0];
                  end
                  OP_C2: begin
                     r_ff <= prod << R_SHIFT;
                  end
                  OP_L: begin
                     if (l_ok) begin
                        s_ff <= cand;
                     end
                     bit_ff <= bit_ff - 4'd1;
                  end
                  default: begin
                     t1_ff <= t1_ff;
                  end
               endcase
            end
         end
         ST_BIT: begin
            if (t_le0 && !neg_ff) begin
               s_ff   <= cand;
               bit_ff <= bit_ff - 4'd1;
            end else if (t_pos && neg_ff) begin
               bit_ff <= bit_ff - 4'd1;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_score_ff <= flat_ff ? '0 : s_ff;
               rsp_flat_ff  <= flat_ff;
            end
         end
         default: begin
            s_ff <= s_ff;
         end
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_score_ff;
   assign rsp_tuser  = rsp_flat_ff;

endmodule

// ===== rtl/core/weighted_normalized_cross_correlation_unit.sv =====
// Top level of the weighted normalized cross-correlation unit.
//
// Input stream (req_*): one transaction per spectral bin carrying image and
// reference magnitudes (unsigned 12.8) and a weight (256 = 1.0); req_tlast
// marks the final bin of a data set. Bins are taken one per cycle while req_tready is high.
// Result stream (rsp_*): one transaction per data set, rsp_tdata = score as an
// unsigned 0.16 fraction of (ncc+1)/2, rsp_tuser = flat flag (score 0).
// A bin passes through the s1 and s2 registers before it is added to the sums;
// after the last bin the back end's time is set by the shared 32x32 limb
// multiplier, which it uses for each variance and covariance product and once
// more for each score bit that needs a compare.
// A two-deep snapshot queue lets the next data set stream in while the back
// end still works; the input stalls only when the queue is full and a further
// last bin arrives.
// Reset clears the sums, the queue and the result valid flag; no clearing pass.
// When the receiver stalls, the result stays in the output register and the
// back end waits before posting the next one.
module weighted_normalized_cross_correlation_unit import wncc_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [REQ_DATA_BITS-1:0] req_tdata,  // img_mag, ref_mag, weight, zero fill
   input  logic                     req_tlast,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [SCORE_BITS-1:0]    rsp_tdata,  // score
   output logic                     rsp_tuser   // flat_input
);

   logic     q_push, q_full, q_pop, q_empty;
   sums_type q_wdata, q_rdata;

   wncc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .q_push     (q_push),
      .q_data     (q_wdata),
      .q_full     (q_full)
   );

   wncc_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (q_push),
      .wr_data (q_wdata),
      .full    (q_full),
      .rd_en   (q_pop),
      .rd_data (q_rdata),
      .empty   (q_empty)
   );

   wncc_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_empty    (q_empty),
      .q_pop      (q_pop),
      .q_data     (q_rdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule
